>>> design/touch_calibrate_and_average_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch calibration block
// Concurrent check wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CALIBRATE_AND_AVERAGE_DEFINES_SVH
`define TOUCH_CALIBRATE_AND_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define TCA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("touch calibration check failed");

// The condition must never be true outside reset.
`define TCA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("touch calibration forbidden condition seen");

`else

`define TCA_ASSERT(label, clk, rst_n, prop)
`define TCA_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> design/tca_pkg.sv
// ----------------------------------------------------------------------------
// Touch calibration package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package tca_pkg;

  // Coordinate and product widths.
  localparam int unsigned DATA_W = 12;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam logic [DATA_W-1:0] MAX_COORD = '1;

  // Configuration port index width.
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values.
  localparam logic [DATA_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
  localparam logic [DATA_W-1:0] RST_SCREEN_HEIGHT = 12'd240;
  localparam logic [1:0]        RST_ROTATION      = 2'd0;
  localparam logic [DATA_W-1:0] RST_RAW_LOW       = 12'd200;
  localparam logic [DATA_W-1:0] RST_RAW_HIGH      = 12'd3800;

  // Parameter defaults.
  localparam int unsigned WINDOW_DEF  = 4;
  localparam bit          SWAP_XY_DEF = 1'b0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_ROTATION      = 3'd2,
    CFG_RAW_X_LOW     = 3'd3,
    CFG_RAW_X_HIGH    = 3'd4,
    CFG_RAW_Y_LOW     = 3'd5,
    CFG_RAW_Y_HIGH    = 3'd6
  } cfg_idx_e;

  // Status of a multi-cycle unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> design/touch_calibrate_and_average.sv
// ----------------------------------------------------------------------------
// Touch calibration and averaging
// Maps raw touch converter samples to screen coordinates and smooths them.
// ----------------------------------------------------------------------------
// Usage: one raw sample pair enters on the input channel when in_valid_i is
// high and in_stall_o is low. Two calibration lanes, one per axis, remove the
// offset and scale by screen size over the raw span with a serial divider of
// 24 steps each; the averaging stage then adds the pair to a moving window
// and divides the running sums by the fill count in a second pair of serial
// dividers of 12 + $clog2(WINDOW+1) steps.
// A result follows its item through the lane product register, the lane
// dividers, the window and sum update and the averaging dividers into the
// output register. One item is processed at a time, so a new item is not
// accepted until the previous result has left the datapath.
// The result waits in an output register while out_stall_i is high; the next
// item is taken as soon as the previous result leaves the datapath, and a
// finished result that cannot be stored holds the datapath until it can.
// Reset loads the default calibration registers and empties the window.
// Configuration writes are always ready and should only be issued while no
// item is in flight.
// ----------------------------------------------------------------------------
`include "touch_calibrate_and_average_defines.svh"

module touch_calibrate_and_average #(
  parameter int unsigned WINDOW  = tca_pkg::WINDOW_DEF,
  parameter bit          SWAP_XY = tca_pkg::SWAP_XY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tca_pkg::DATA_W-1:0]    raw_x_i,
  input  logic [tca_pkg::DATA_W-1:0]    raw_y_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tca_pkg::DATA_W-1:0]    pos_x_o,
  output logic [tca_pkg::DATA_W-1:0]    pos_y_o,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tca_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tca_pkg::DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DW = tca_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CAL  = 4'b0010,
    S_AVG  = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [DW-1:0]       screen_width_q, screen_height_q;
  logic [1:0]          rotation_q;
  logic [DW-1:0]       raw_x_low_q, raw_x_high_q, raw_y_low_q, raw_y_high_q;
  logic                in_accept;
  logic                cfg_write;
  logic [DW-1:0]       raw_a, raw_b;
  logic                mirror;
  logic [DW-1:0]       size_x, size_y;
  tca_pkg::unit_stat_t lane_x_stat, lane_y_stat, avg_stat;
  logic [DW-1:0]       cal_x, cal_y;
  logic [DW-1:0]       mean_x, mean_y;
  logic                out_free;
  logic                out_load;
  logic                out_valid_q, out_valid_d;
  logic [DW-1:0]       pos_x_q, pos_y_q;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = state_q != S_IDLE;
  assign in_accept   = in_valid_i & ~in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= tca_pkg::RST_SCREEN_WIDTH;
      screen_height_q <= tca_pkg::RST_SCREEN_HEIGHT;
      rotation_q      <= tca_pkg::RST_ROTATION;
      raw_x_low_q     <= tca_pkg::RST_RAW_LOW;
      raw_x_high_q    <= tca_pkg::RST_RAW_HIGH;
      raw_y_low_q     <= tca_pkg::RST_RAW_LOW;
      raw_y_high_q    <= tca_pkg::RST_RAW_HIGH;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        tca_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        tca_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        tca_pkg::CFG_ROTATION:      rotation_q      <= cfg_data_i[1:0];
        tca_pkg::CFG_RAW_X_LOW:     raw_x_low_q     <= cfg_data_i;
        tca_pkg::CFG_RAW_X_HIGH:    raw_x_high_q    <= cfg_data_i;
        tca_pkg::CFG_RAW_Y_LOW:     raw_y_low_q     <= cfg_data_i;
        tca_pkg::CFG_RAW_Y_HIGH:    raw_y_high_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Optional axis exchange and rotation-dependent scale sizes.
  assign raw_a  = SWAP_XY ? raw_y_i : raw_x_i;
  assign raw_b  = SWAP_XY ? raw_x_i : raw_y_i;
  assign mirror = ~rotation_q[0];
  assign size_x = rotation_q[0] ? screen_height_q : screen_width_q;
  assign size_y = rotation_q[0] ? screen_width_q : screen_height_q;

  // One calibration lane per axis.
  tca_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .raw_i    (raw_a),
    .low_i    (raw_x_low_q),
    .high_i   (raw_x_high_q),
    .size_i   (size_x),
    .mirror_i (mirror),
    .stat_o   (lane_x_stat),
    .cal_o    (cal_x)
  );

  tca_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .raw_i    (raw_b),
    .low_i    (raw_y_low_q),
    .high_i   (raw_y_high_q),
    .size_i   (size_y),
    .mirror_i (mirror),
    .stat_o   (lane_y_stat),
    .cal_o    (cal_y)
  );

  // Both lanes finish together and feed the averaging stage.
  tca_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (lane_x_stat.done & lane_y_stat.done),
    .cal_x_i (cal_x),
    .cal_y_i (cal_y),
    .stat_o  (avg_stat),
    .pos_x_o (mean_x),
    .pos_y_o (mean_y)
  );

  // Output register is free when empty or being taken this cycle.
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Sequencer for one item at a time.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CAL;
        end
      end
      S_CAL: begin
        if (lane_x_stat.done) begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        if (avg_stat.done) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_x_q <= mean_x;
      pos_y_q <= mean_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;

  // The two lanes run in lockstep.
  `TCA_ASSERT_NEVER(a_lanes_lockstep, clk_i, rst_ni, lane_x_stat.done != lane_y_stat.done)
  // No unit is working while the block waits for an item.
  `TCA_ASSERT(a_idle_quiet, clk_i, rst_ni,
              state_q == S_IDLE |-> !lane_x_stat.busy && !lane_y_stat.busy && !avg_stat.busy)
  // The averaging result only appears while the sequencer waits for it.
  `TCA_ASSERT(a_avg_done_in_avg, clk_i, rst_ni, avg_stat.done |-> state_q == S_AVG)
  // A new result is loaded only from the averaging or hold states.
  `TCA_ASSERT(a_out_source, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == S_AVG || state_q == S_HOLD))

endmodule

>>> design/tca_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tca_div #(
  parameter int unsigned N = tca_pkg::PROD_W,
  parameter int unsigned M = tca_pkg::DATA_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [N-1:0]        dividend_i,
  input  logic [M-1:0]        divisor_i,
  output tca_pkg::unit_stat_t stat_o,
  output logic [N-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [N-1:0]     dq_q, dq_d;
  logic [M-1:0]     rem_q, rem_d;
  logic [M-1:0]     divisor_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [M:0]       trial;
  logic [M:0]       diff;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, dq_q[N-1]};
  assign ge    = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(N);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dq_d  = {dq_q[N-2:0], ge};
      rem_d = ge ? diff[M-1:0] : trial[M-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dq_q;

endmodule

>>> design/tca_lane.sv
// ----------------------------------------------------------------------------
// Calibration lane
// Offset, scale by size over span, saturate and mirror one axis.
// ----------------------------------------------------------------------------
module tca_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tca_pkg::DATA_W-1:0]   raw_i,
  input  logic [tca_pkg::DATA_W-1:0]   low_i,
  input  logic [tca_pkg::DATA_W-1:0]   high_i,
  input  logic [tca_pkg::DATA_W-1:0]   size_i,
  input  logic                         mirror_i,
  output tca_pkg::unit_stat_t          stat_o,
  output logic [tca_pkg::DATA_W-1:0]   cal_o
);

  localparam int unsigned DW = tca_pkg::DATA_W;
  localparam int unsigned PW = tca_pkg::PROD_W;

  logic [DW-1:0]       offs;
  logic [PW-1:0]       prod_q;
  logic [DW-1:0]       span_q;
  logic [DW-1:0]       size_q;
  logic                zero_q;
  logic                mirror_q;
  logic                go_q;
  logic                done_q;
  logic [DW-1:0]       cal_q;
  logic [PW-1:0]       quo;
  logic [DW-1:0]       scaled;
  logic [DW-1:0]       result;
  tca_pkg::unit_stat_t div_stat;

  // Offset removal, saturating at zero.
  assign offs = (raw_i > low_i) ? (raw_i - low_i) : '0;

  // Capture the product and the span when the item arrives.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q   <= PW'(offs) * PW'(size_i);
      span_q   <= high_i - low_i;
      zero_q   <= high_i <= low_i;
      size_q   <= size_i;
      mirror_q <= mirror_i;
    end
  end

  // The divider starts in the cycle after the product is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      go_q   <= start_i;
      done_q <= div_stat.done;
    end
  end

  tca_div #(
    .N (PW),
    .M (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  // Saturate the quotient, force zero for an empty span, then mirror.
  always_comb begin
    if (zero_q) begin
      scaled = '0;
    end else if (quo > PW'(tca_pkg::MAX_COORD)) begin
      scaled = tca_pkg::MAX_COORD;
    end else begin
      scaled = quo[DW-1:0];
    end
    if (mirror_q) begin
      result = (size_q > scaled) ? (size_q - scaled) : '0;
    end else begin
      result = scaled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_stat.done) begin
      cal_q <= result;
    end
  end

  assign stat_o.busy = go_q | div_stat.busy;
  assign stat_o.done = done_q;
  assign cal_o       = cal_q;

endmodule

>>> design/tca_avg.sv
// ----------------------------------------------------------------------------
// Averaging stage
// Merges both lanes into a moving-average window and divides by its fill.
// ----------------------------------------------------------------------------
module tca_avg #(
  parameter int unsigned WINDOW = tca_pkg::WINDOW_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       upd_i,
  input  logic [tca_pkg::DATA_W-1:0] cal_x_i,
  input  logic [tca_pkg::DATA_W-1:0] cal_y_i,
  output tca_pkg::unit_stat_t        stat_o,
  output logic [tca_pkg::DATA_W-1:0] pos_x_o,
  output logic [tca_pkg::DATA_W-1:0] pos_y_o
);

  localparam int unsigned DW    = tca_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = DW + CNT_W;

  logic [DW-1:0]       win_x_q [WINDOW];
  logic [DW-1:0]       win_y_q [WINDOW];
  logic [CNT_W-1:0]    fill_q;
  logic [SUM_W-1:0]    sum_x_q, sum_y_q;
  logic [SUM_W-1:0]    drop_x, drop_y;
  logic                full;
  logic                go_q;
  logic [SUM_W-1:0]    quo_x, quo_y;
  tca_pkg::unit_stat_t div_x_stat, div_y_stat;

  // The oldest entry leaves the running sum once the window is full.
  assign full   = fill_q == CNT_W'(WINDOW);
  assign drop_x = full ? SUM_W'(win_x_q[WINDOW-1]) : '0;
  assign drop_y = full ? SUM_W'(win_y_q[WINDOW-1]) : '0;

  // Window shift line, newest entry first.
  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      for (int i = WINDOW - 1; i > 0; i--) begin
        win_x_q[i] <= win_x_q[i-1];
        win_y_q[i] <= win_y_q[i-1];
      end
      win_x_q[0] <= cal_x_i;
      win_y_q[0] <= cal_y_i;
    end
  end

  // Fill count and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      go_q    <= 1'b0;
    end else begin
      go_q <= upd_i;
      if (upd_i) begin
        sum_x_q <= sum_x_q + SUM_W'(cal_x_i) - drop_x;
        sum_y_q <= sum_y_q + SUM_W'(cal_y_i) - drop_y;
        if (!full) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
    end
  end

  // Mean of each axis over the filled entries.
  tca_div #(
    .N (SUM_W),
    .M (CNT_W)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (sum_x_q),
    .divisor_i  (fill_q),
    .stat_o     (div_x_stat),
    .quotient_o (quo_x)
  );

  tca_div #(
    .N (SUM_W),
    .M (CNT_W)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (sum_y_q),
    .divisor_i  (fill_q),
    .stat_o     (div_y_stat),
    .quotient_o (quo_y)
  );

  assign stat_o.busy = go_q | div_x_stat.busy | div_y_stat.busy;
  assign stat_o.done = div_x_stat.done & div_y_stat.done;
  assign pos_x_o     = quo_x[DW-1:0];
  assign pos_y_o     = quo_y[DW-1:0];

endmodule

>>> verif/touch_calibrate_and_average_tb.sv
// ----------------------------------------------------------------------------
// Testbench for touch_calibrate_and_average
// A short directed table walks through the calibration corner cases, then
// several random phases run under different register settings and traffic
// shapes. Every result is compared against an in-bench model of the
// calibration and moving-average datapath.
// ----------------------------------------------------------------------------
module touch_calibrate_and_average_tb;

  localparam int unsigned DATA_W          = tca_pkg::DATA_W;
  localparam int unsigned CFG_IDX_W       = tca_pkg::CFG_IDX_W;
  localparam logic [DATA_W-1:0] MAX_COORD = tca_pkg::MAX_COORD;
  localparam int unsigned WIN_SIZE        = tca_pkg::WINDOW_DEF;
  localparam bit          SWAP_AXES       = tca_pkg::SWAP_XY_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 130;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned STUCK_LIMIT     = 5000;
  localparam int          DIR_ROWS        = 44;

  // Register index past the end of the register list; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  // Display rotation codes.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } pos_t;

  // One row of the directed table: either a sample pair or a register write.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    a;
    logic [DATA_W-1:0]    b;
    logic                 check;
    logic [DATA_W-1:0]    ex;
    logic [DATA_W-1:0]    ey;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [DATA_W-1:0]    raw_x_i;
  logic [DATA_W-1:0]    raw_y_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DATA_W-1:0]    pos_x_o;
  logic [DATA_W-1:0]    pos_y_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;

  // Calibration registers as the model sees them.
  logic [DATA_W-1:0] cal_width;
  logic [DATA_W-1:0] cal_height;
  logic [1:0]        cal_rot;
  logic [DATA_W-1:0] cal_x_lo;
  logic [DATA_W-1:0] cal_x_hi;
  logic [DATA_W-1:0] cal_y_lo;
  logic [DATA_W-1:0] cal_y_hi;

  // Moving-average window, newest entry first.
  logic [DATA_W-1:0] avg_win_x [WIN_SIZE];
  logic [DATA_W-1:0] avg_win_y [WIN_SIZE];
  int unsigned       avg_fill;

  pos_t        pos_expected_q [$];
  pos_t        want_pos;
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;

  // Directed table. Expected values are typed in only where the whole window
  // holds one value, so the mean is obvious.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // Reset calibration: raw at and below the minimum both mirror to full size.
    '{ROW_ITEM, '0, 12'd200, 12'd200, 1'b1, 12'd320, 12'd240},
    '{ROW_ITEM, '0, 12'd0, 12'd0, 1'b1, 12'd320, 12'd240},
    // Full-scale raw scales past the screen size, so the mirror bottoms out.
    '{ROW_ITEM, '0, 12'd4095, 12'd4095, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd1900, 12'd2000, 1'b0, '0, '0},
    // Rotation written with upper bits set; only the low two bits stick.
    '{ROW_CFG, tca_pkg::CFG_ROTATION, 12'hFFD, '0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_IDX_UNUSED, 12'hABC, '0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd4095, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd200, 12'd3800, 1'b0, '0, '0},
    // Span of one on x drives the scaled value into saturation.
    '{ROW_CFG, tca_pkg::CFG_SCREEN_WIDTH, 12'd4095, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_SCREEN_HEIGHT, 12'd4095, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_X_LOW, 12'd0, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_X_HIGH, 12'd1, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_Y_LOW, 12'd0, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_Y_HIGH, 12'd4095, '0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd4095, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd4095, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd4095, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd4095, 1'b1, 12'd4095, 12'd4095},
    // Zero span on x and an inverted span on y both give zero.
    '{ROW_CFG, tca_pkg::CFG_RAW_X_HIGH, 12'd0, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_Y_LOW, 12'd4095, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_Y_HIGH, 12'd100, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_ROTATION, 12'd3, '0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd1234, 12'd3000, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd1234, 12'd3000, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd1234, 12'd3000, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd1234, 12'd3000, 1'b1, 12'd0, 12'd0},
    // Zero screen size with mirroring: scale and mirror both give zero.
    '{ROW_CFG, tca_pkg::CFG_ROTATION, 12'd2, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_SCREEN_WIDTH, 12'd0, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_SCREEN_HEIGHT, 12'd0, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_X_HIGH, 12'd4095, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_Y_LOW, 12'd0, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_RAW_Y_HIGH, 12'd4095, '0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 12'd0, 1'b1, 12'd0, 12'd0},
    // Smallest and largest sizes side by side.
    '{ROW_CFG, tca_pkg::CFG_ROTATION, 12'd0, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_SCREEN_WIDTH, 12'd1, '0, 1'b0, '0, '0},
    '{ROW_CFG, tca_pkg::CFG_SCREEN_HEIGHT, 12'd4095, '0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd0, 12'd0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd0, 12'd0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd0, 12'd0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, 12'd0, 12'd0, 1'b1, 12'd1, 12'd4095},
    '{ROW_ITEM, '0, 12'd4095, 12'd4095, 1'b0, '0, '0}
  };

  touch_calibrate_and_average #(
    .WINDOW  (WIN_SIZE),
    .SWAP_XY (SWAP_AXES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a 20 unit period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offset, scale and optional mirror of one axis.
  function automatic logic [DATA_W-1:0] calibrate_axis(input logic [DATA_W-1:0] raw,
                                                       input logic [DATA_W-1:0] lo,
                                                       input logic [DATA_W-1:0] hi,
                                                       input logic [DATA_W-1:0] size,
                                                       input bit mirror);
    int unsigned offs;
    int unsigned scaled;
    offs = (raw > lo) ? int'(raw) - int'(lo) : 0;
    scaled = 0;
    if (hi > lo) begin
      scaled = (offs * int'(size)) / (int'(hi) - int'(lo));
      if (scaled > int'(MAX_COORD)) scaled = int'(MAX_COORD);
    end
    if (mirror) scaled = (int'(size) > scaled) ? int'(size) - scaled : 0;
    return scaled[DATA_W-1:0];
  endfunction

  // Calibrate one sample pair, push it into the window and return the mean.
  function automatic pos_t advance_position(input logic [DATA_W-1:0] rx,
                                            input logic [DATA_W-1:0] ry);
    logic [DATA_W-1:0] ax;
    logic [DATA_W-1:0] ay;
    bit                mirror;
    int unsigned       sx;
    int unsigned       sy;
    pos_t              p;
    ax = SWAP_AXES ? ry : rx;
    ay = SWAP_AXES ? rx : ry;
    mirror = (cal_rot == ROT_0) || (cal_rot == ROT_180);
    for (int i = WIN_SIZE - 1; i > 0; i--) begin
      avg_win_x[i] = avg_win_x[i-1];
      avg_win_y[i] = avg_win_y[i-1];
    end
    if (mirror) begin
      avg_win_x[0] = calibrate_axis(ax, cal_x_lo, cal_x_hi, cal_width, 1'b1);
      avg_win_y[0] = calibrate_axis(ay, cal_y_lo, cal_y_hi, cal_height, 1'b1);
    end else begin
      avg_win_x[0] = calibrate_axis(ax, cal_x_lo, cal_x_hi, cal_height, 1'b0);
      avg_win_y[0] = calibrate_axis(ay, cal_y_lo, cal_y_hi, cal_width, 1'b0);
    end
    if (avg_fill < WIN_SIZE) avg_fill++;
    sx = 0;
    sy = 0;
    for (int i = 0; i < avg_fill; i++) begin
      sx += int'(avg_win_x[i]);
      sy += int'(avg_win_y[i]);
    end
    sx = sx / avg_fill;
    sy = sy / avg_fill;
    p.x = sx[DATA_W-1:0];
    p.y = sy[DATA_W-1:0];
    return p;
  endfunction

  // Raw reading: mostly inside the calibrated span with a small margin,
  // sometimes anywhere, sometimes a rail.
  function automatic logic [DATA_W-1:0] pick_raw(input logic [DATA_W-1:0] lo,
                                                 input logic [DATA_W-1:0] hi);
    int unsigned sel;
    int unsigned a;
    int unsigned b;
    sel = $urandom_range(99);
    if (sel < 8) return ($urandom_range(1) != 0) ? MAX_COORD : '0;
    if (sel < 30 || hi <= lo) return DATA_W'($urandom_range(4095));
    a = (lo > 32) ? int'(lo) - 32 : 0;
    b = (hi < 4063) ? int'(hi) + 32 : 4095;
    return DATA_W'($urandom_range(b, a));
  endfunction

  // Screen size: mostly realistic, with the extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return 12'd1;
    if (sel < 20) return MAX_COORD;
    if (sel < 25) return '0;
    if (sel < 60) return DATA_W'($urandom_range(1024, 100));
    return DATA_W'($urandom_range(4095, 1));
  endfunction

  // Write one register and track it in the model.
  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      tca_pkg::CFG_SCREEN_WIDTH:  cal_width  = data;
      tca_pkg::CFG_SCREEN_HEIGHT: cal_height = data;
      tca_pkg::CFG_ROTATION:      cal_rot    = data[1:0];
      tca_pkg::CFG_RAW_X_LOW:     cal_x_lo   = data;
      tca_pkg::CFG_RAW_X_HIGH:    cal_x_hi   = data;
      tca_pkg::CFG_RAW_Y_LOW:     cal_y_lo   = data;
      tca_pkg::CFG_RAW_Y_HIGH:    cal_y_hi   = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Offer one sample pair, after an optional random gap, and record the
  // expected coordinates once the block takes it.
  task automatic offer_sample(input logic [DATA_W-1:0] rx, input logic [DATA_W-1:0] ry,
                              input bit use_typed, input pos_t typed);
    pos_t p;
    if ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      raw_x_i    <= DATA_W'($urandom_range(4095));
      raw_y_i    <= DATA_W'($urandom_range(4095));
      do @(negedge clk_i); while ($urandom_range(99) < tx_gap_pct);
    end
    in_valid_i <= 1'b1;
    raw_x_i    <= rx;
    raw_y_i    <= ry;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = advance_position(rx, ry);
    pos_expected_q.push_back(use_typed ? typed : p);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every pending result has come out.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pos_expected_q.size() != 0);
  endtask

  // One random phase: new register settings, a traffic shape, then items.
  task automatic run_phase(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                           input logic [DATA_W-1:0] rot_data,
                           input logic [DATA_W-1:0] xl, input logic [DATA_W-1:0] xh,
                           input logic [DATA_W-1:0] yl, input logic [DATA_W-1:0] yh,
                           input idle_mode_e mode, input bit with_hold);
    quiesce();
    apply_config(tca_pkg::CFG_SCREEN_WIDTH, w);
    apply_config(tca_pkg::CFG_SCREEN_HEIGHT, h);
    apply_config(tca_pkg::CFG_ROTATION, rot_data);
    apply_config(tca_pkg::CFG_RAW_X_LOW, xl);
    apply_config(tca_pkg::CFG_RAW_X_HIGH, xh);
    apply_config(tca_pkg::CFG_RAW_Y_LOW, yl);
    apply_config(tca_pkg::CFG_RAW_Y_HIGH, yh);
    cfg_valid_i <= 1'b0;
    case (mode)
      IDLE_NONE: begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      IDLE_SEND: begin
        tx_gap_pct   = 86;
        rx_stall_pct = 0;
      end
      IDLE_RECV: begin
        tx_gap_pct   = 0;
        rx_stall_pct = 86;
      end
      default: begin
        tx_gap_pct   = 31;
        rx_stall_pct = 31;
      end
    endcase
    if (with_hold) hold_req++;
    repeat (ITEMS_PER_PHASE) offer_sample(pick_raw(xl, xh), pick_raw(yl, yh), 1'b0, '0);
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the
  // block backs up and stalls its input.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_ack = hold_req;
      end
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare each result with the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pos_expected_q.size() == 0) begin
        $display("%0t: unexpected result pos_x=%0d pos_y=%0d", $time, pos_x_o, pos_y_o);
        mismatch_count++;
      end else begin
        want_pos = pos_expected_q.pop_front();
        if (pos_x_o !== want_pos.x) begin
          $display("%0t: pos_x mismatch, expected %0d, got %0d", $time, want_pos.x, pos_x_o);
          mismatch_count++;
        end
        if (pos_y_o !== want_pos.y) begin
          $display("%0t: pos_y mismatch, expected %0d, got %0d", $time, want_pos.y, pos_y_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
        $display("FAIL touch_calibrate_and_average");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    bit                cfg_open;
    logic [DATA_W-1:0] xl;
    logic [DATA_W-1:0] xh;
    logic [DATA_W-1:0] yl;
    logic [DATA_W-1:0] yh;
    idle_mode_e        rand_modes [4];
    rand_modes  = '{IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
    cfg_open    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    raw_x_i     = '0;
    raw_y_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tca_pkg::CFG_SCREEN_WIDTH;
    cfg_data_i  = '0;
    cal_width   = tca_pkg::RST_SCREEN_WIDTH;
    cal_height  = tca_pkg::RST_SCREEN_HEIGHT;
    cal_rot     = tca_pkg::RST_ROTATION;
    cal_x_lo    = tca_pkg::RST_RAW_LOW;
    cal_x_hi    = tca_pkg::RST_RAW_HIGH;
    cal_y_lo    = tca_pkg::RST_RAW_LOW;
    cal_y_hi    = tca_pkg::RST_RAW_HIGH;
    avg_fill    = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; register writes only once the block has drained.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (!cfg_open) begin
          quiesce();
          cfg_open = 1'b1;
        end
        apply_config(dir_rows[r].idx, dir_rows[r].a);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        offer_sample(dir_rows[r].a, dir_rows[r].b, dir_rows[r].check,
                     {dir_rows[r].ex, dir_rows[r].ey});
      end
    end

    // Largest sizes and full spans, then the reset calibration rotated.
    run_phase(MAX_COORD, MAX_COORD, DATA_W'(ROT_0), '0, MAX_COORD, '0, MAX_COORD,
              IDLE_NONE, 1'b0);
    run_phase(tca_pkg::RST_SCREEN_WIDTH, tca_pkg::RST_SCREEN_HEIGHT, DATA_W'(ROT_90),
              tca_pkg::RST_RAW_LOW, tca_pkg::RST_RAW_HIGH,
              tca_pkg::RST_RAW_LOW, tca_pkg::RST_RAW_HIGH, IDLE_SEND, 1'b0);

    // Random settings; spans are occasionally empty or inverted.
    for (int p = 0; p < 4; p++) begin
      xl = DATA_W'($urandom_range(1200));
      xh = DATA_W'($urandom_range(4095, 2400));
      yl = DATA_W'($urandom_range(1200));
      yh = DATA_W'($urandom_range(4095, 2400));
      if ($urandom_range(7) == 0) {xl, xh} = {xh, xl};
      if ($urandom_range(15) == 0) yh = yl;
      run_phase(pick_size(), pick_size(), DATA_W'($urandom_range(4095)), xl, xh, yl, yh,
                rand_modes[p], p == 2);
    end

    // Smallest nonzero sizes.
    run_phase(12'd1, 12'd1, DATA_W'(ROT_270), '0, MAX_COORD, '0, MAX_COORD,
              IDLE_SEND, 1'b0);

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS touch_calibrate_and_average");
    end else begin
      $display("FAIL touch_calibrate_and_average");
    end
    $finish;
  end

endmodule

>>> touch_calibrate_and_average.f
+incdir+design
design/tca_pkg.sv
design/tca_div.sv
design/tca_lane.sv
design/tca_avg.sv
design/touch_calibrate_and_average.sv
verif/touch_calibrate_and_average_tb.sv
